// ===== design/npc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants of the nearest palette colour block
// Component, index and distance widths, request kind codes and the search
// token that travels along the row of palette cells.
// ----------------------------------------------------------------------------
package npc_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam int COMP_W  = 8;
   localparam int INDEX_W = 8;
   localparam int DIST_W  = 10;

   // Start value of the running best: above any real distance (765)
   localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } colour_type;

   typedef struct packed {
      logic               valid;
      colour_type         colour;
      logic [INDEX_W-1:0] best_index;
      logic [DIST_W-1:0]  best_distance;
   } token_type;

endpackage

// ===== design/npc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_cell: one palette entry with its distance stage
// Holds one palette colour, takes writes addressed to it and, as a search
// token passes, compares its colour with the query and hands on the best.
// ----------------------------------------------------------------------------
module npc_cell import npc_pkg::*; #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [INDEX_W-1:0] wr_index,
   input  colour_type         wr_colour,
   input  token_type          tok_prev,
   output token_type          tok_next
);

   // Cells from 256 up cannot be addressed by an 8-bit index
   localparam logic ADDRESSABLE = (CELL_INDEX < (1 << INDEX_W));
   localparam logic [INDEX_W-1:0] OWN_INDEX = INDEX_W'(CELL_INDEX);

   colour_type          entry_ff, entry_in;
   token_type           tok_ff, tok_in;
   logic [COMP_W-1:0]   diff_r, diff_g, diff_b;
   logic [DIST_W-1:0]   entry_distance;
   logic                wr_hit;

   // Decode a write to this entry
   assign wr_hit = wr_en && ADDRESSABLE && (wr_index == OWN_INDEX);

   always_comb begin
      entry_in = wr_hit ? wr_colour : entry_ff;
   end

   // Distance of the passing query to this entry
   always_comb begin
      diff_r = (tok_prev.colour.red > entry_ff.red) ?
               tok_prev.colour.red - entry_ff.red : entry_ff.red - tok_prev.colour.red;
      diff_g = (tok_prev.colour.green > entry_ff.green) ?
               tok_prev.colour.green - entry_ff.green :
               entry_ff.green - tok_prev.colour.green;
      diff_b = (tok_prev.colour.blue > entry_ff.blue) ?
               tok_prev.colour.blue - entry_ff.blue : entry_ff.blue - tok_prev.colour.blue;
      entry_distance = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
   end

   // Take over the best only on a strictly smaller distance: ties keep the lower index
   always_comb begin
      tok_in = tok_prev;
      if (entry_distance < tok_prev.best_distance) begin
         tok_in.best_index    = OWN_INDEX;
         tok_in.best_distance = entry_distance;
      end
   end

   // Hold the entry; clear it at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   // Advance the token; only the valid bit is cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.colour        <= tok_in.colour;
      tok_ff.best_index    <= tok_in.best_index;
      tok_ff.best_distance <= tok_in.best_distance;
   end

   assign tok_next = tok_ff;

endmodule

// ===== design/nearest_palette_color_top.sv =====
`timescale 1ns / 1ps
// Responses: a write request is stored in its entry when accepted and gives no response; a query
//   request gives its strobe as the search token, stepping through one palette cell per cycle,
//   leaves the last cell.
// Throughput: one write per cycle while not busy; a new query is taken only once busy drops.
// Reset: synchronous, clears every palette entry to black and drops any search.
// The receiver cannot stall: each response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// nearest_palette_color_top: palette store with nearest-colour search
// A row of palette cells; a query token walks the row, keeping the entry with the
// least sum of absolute component differences, lowest index on ties.
// ----------------------------------------------------------------------------
module nearest_palette_color_top import npc_pkg::*; #(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [COMP_W-1:0]  req_red,
   input  logic [COMP_W-1:0]  req_green,
   input  logic [COMP_W-1:0]  req_blue,
   output logic               rsp_valid,
   output logic [INDEX_W-1:0] rsp_best_index,
   output logic [DIST_W-1:0]  rsp_best_distance
);

   token_type  chain [PALETTE_ENTRIES+1];
   colour_type req_colour;
   logic       accept;
   logic       wr_en;
   logic       launch;
   logic       busy_ff, busy_in;

   assign accept     = start && !busy_ff;
   assign wr_en      = accept && (req_kind == KIND_WRITE);
   assign launch     = accept && (req_kind == KIND_QUERY);
   assign req_colour = '{red: req_red, green: req_green, blue: req_blue};

   // Launch a fresh search token into the first cell
   always_comb begin
      chain[0].valid         = launch;
      chain[0].colour        = req_colour;
      chain[0].best_index    = '0;
      chain[0].best_distance = DIST_NONE;
   end

   // Row of palette cells
   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      npc_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (wr_en),
         .wr_index  (req_entry_index),
         .wr_colour (req_colour),
         .tok_prev  (chain[i]),
         .tok_next  (chain[i+1])
      );
   end

   // Hold busy from launch until the token leaves the last cell
   always_comb begin
      busy_in = busy_ff;
      if (launch) begin
         busy_in = 1'b1;
      end else if (chain[PALETTE_ENTRIES].valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy              = busy_ff;
   assign rsp_valid         = chain[PALETTE_ENTRIES].valid;
   assign rsp_best_index    = chain[PALETTE_ENTRIES].best_index;
   assign rsp_best_distance = chain[PALETTE_ENTRIES].best_distance;

endmodule

// ===== tb/nearest_palette_color_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_top_tb: self-checking bench for the palette search
// Drives write and query requests through the start/busy handshake. A
// directed table covers the empty palette, extreme colours, ties and bit
// patterns. Random traffic then fills the palette and queries close to its
// entries. Each query's expected match is taken from the table where typed
// is set, else from a shadow palette, and is checked on the strobe.
// ----------------------------------------------------------------------------
module nearest_palette_color_top_tb;
   import npc_pkg::*;

   localparam int ENTRIES     = PALETTE_ENTRIES_DEF;
   localparam int RANDOM_REQS = 1425;
   localparam int QUIET_TAIL  = 150;
   localparam int DRAIN_WAIT  = ENTRIES + 64;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SHOWN_LIMIT = 10;
   localparam int DIRECTED_N  = 24;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
   } match_type;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] index;
      colour_type         colour;
      logic               typed;
      match_type          answer;
   } stim_row_type;

   // Directed table: answer holds only where typed is set
   localparam stim_row_type DIRECTED [DIRECTED_N] = '{
      '{KIND_QUERY, 8'h00, 24'h000000, 1'b1, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'hff, 24'hffffff, 1'b1, '{8'd0,   10'd765}},
      '{KIND_WRITE, 8'hff, 24'hffffff, 1'b0, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'h55, 24'h000000, 1'b1, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'haa, 24'hffffff, 1'b1, '{8'd255, 10'd0}},
      '{KIND_QUERY, 8'h00, 24'h808080, 1'b0, '{8'd0,   10'd0}},
      '{KIND_WRITE, 8'h00, 24'hff0000, 1'b0, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'h00, 24'h000000, 1'b1, '{8'd1,   10'd0}},
      '{KIND_WRITE, 8'h01, 24'h00ff00, 1'b0, '{8'd0,   10'd0}},
      '{KIND_WRITE, 8'h02, 24'h0000ff, 1'b0, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'hff, 24'h000000, 1'b1, '{8'd3,   10'd0}},
      '{KIND_QUERY, 8'h00, 24'hff0000, 1'b1, '{8'd0,   10'd0}},
      '{KIND_WRITE, 8'h0a, 24'h123456, 1'b0, '{8'd0,   10'd0}},
      '{KIND_WRITE, 8'h14, 24'h123456, 1'b0, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'h14, 24'h123456, 1'b1, '{8'd10,  10'd0}},
      '{KIND_WRITE, 8'h03, 24'haa55aa, 1'b0, '{8'd0,   10'd0}},
      '{KIND_WRITE, 8'h04, 24'h55aa55, 1'b0, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'h00, 24'haa55aa, 1'b1, '{8'd3,   10'd0}},
      '{KIND_QUERY, 8'h00, 24'h55aa55, 1'b1, '{8'd4,   10'd0}},
      '{KIND_WRITE, 8'h80, 24'h808080, 1'b0, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'h7f, 24'h7f7f7f, 1'b0, '{8'd0,   10'd0}},
      '{KIND_WRITE, 8'hfe, 24'hfefefe, 1'b0, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'h01, 24'hfffffe, 1'b0, '{8'd0,   10'd0}},
      '{KIND_QUERY, 8'hfe, 24'h01fe80, 1'b0, '{8'd0,   10'd0}}
   };

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_kind = KIND_WRITE;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic [COMP_W-1:0]  req_red = '0;
   logic [COMP_W-1:0]  req_green = '0;
   logic [COMP_W-1:0]  req_blue = '0;
   logic               rsp_valid;
   logic [INDEX_W-1:0] rsp_best_index;
   logic [DIST_W-1:0]  rsp_best_distance;

   colour_type shadow_palette [ENTRIES];
   match_type  pending_matches [$];
   int         mismatch_count = 0;
   int         cycle_count = 0;

   nearest_palette_color_top #(.PALETTE_ENTRIES(ENTRIES)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int component_gap(input logic [COMP_W-1:0] a, input logic [COMP_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // Scan the shadow palette; strict less-than keeps the lowest index on ties
   function automatic match_type find_nearest(input colour_type c);
      match_type best;
      int        best_d;
      int        d;
      best_d = 1 << 30;
      best   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         d = component_gap(c.red, shadow_palette[i].red)
           + component_gap(c.green, shadow_palette[i].green)
           + component_gap(c.blue, shadow_palette[i].blue);
         if (d < best_d) begin
            best_d        = d;
            best.index    = INDEX_W'(i);
            best.distance = DIST_W'(d);
         end
      end
      return best;
   endfunction

   // Move a component a few steps either way, clamped to its range
   function automatic logic [COMP_W-1:0] nudge(input logic [COMP_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return COMP_W'(v);
   endfunction

   function automatic logic [COMP_W-1:0] extreme_component();
      return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= SHOWN_LIMIT) $display("mismatch: %s", what);
   endtask

   // Hold the request until it is taken, then update the shadow palette or
   // queue the expected match
   task automatic issue_request(input logic kind, input logic [INDEX_W-1:0] index,
                                input colour_type colour, input logic typed,
                                input match_type answer);
      req_kind        <= kind;
      req_entry_index <= index;
      req_red         <= colour.red;
      req_green       <= colour.green;
      req_blue        <= colour.blue;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (kind == KIND_WRITE)
         shadow_palette[index] = colour;
      else
         pending_matches.push_back(typed ? answer : find_nearest(colour));
   endtask

   // Drop start for a random burst, except in quiet stretches and the tail
   task automatic maybe_pause(input int n);
      if (n < DIRECTED_N + RANDOM_REQS - QUIET_TAIL && (n / 100) % 3 != 2
          && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Check each strobe against the oldest expected match
   always @(posedge clock) begin
      match_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_matches.size() == 0) begin
            report_mismatch($sformatf("response with no query outstanding: index %0d distance %0d",
                                      rsp_best_index, rsp_best_distance));
         end else begin
            want = pending_matches.pop_front();
            if (rsp_best_index !== want.index)
               report_mismatch($sformatf("best_index expected %0d got %0d",
                                         want.index, rsp_best_index));
            if (rsp_best_distance !== want.distance)
               report_mismatch($sformatf("best_distance expected %0d got %0d",
                                         want.distance, rsp_best_distance));
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("nearest_palette_color_top_tb: errors");
         $finish;
      end
   end

   initial begin
      logic               kind;
      logic [INDEX_W-1:0] index;
      colour_type         colour;
      colour_type         seed_colour;
      int                 sel;
      int                 n;
      for (int i = 0; i < ENTRIES; i++) shadow_palette[i] = '0;
      n = 0;

      // Hold reset, release on a clock edge
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (int r = 0; r < DIRECTED_N; r++) begin
         issue_request(DIRECTED[r].kind, DIRECTED[r].index, DIRECTED[r].colour,
                       DIRECTED[r].typed, DIRECTED[r].answer);
         maybe_pause(n);
         n++;
      end

      // Random traffic: writes build up the palette, queries land on or near it
      for (int r = 0; r < RANDOM_REQS; r++) begin
         sel         = $urandom_range(0, 99);
         index       = INDEX_W'($urandom_range(0, 255));
         seed_colour = shadow_palette[$urandom_range(0, ENTRIES - 1)];
         colour      = colour_type'($urandom_range(0, 24'hffffff));
         if (sel < 55) begin
            kind = KIND_WRITE;
            if ($urandom_range(0, 4) == 0) index = INDEX_W'($urandom_range(0, 7));
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
               colour = seed_colour;
            end else if (sel < 3) begin
               colour = '{extreme_component(), extreme_component(), extreme_component()};
            end else if (sel < 4) begin
               colour = '{nudge(seed_colour.red), nudge(seed_colour.green),
                          nudge(seed_colour.blue)};
            end
         end else begin
            kind = KIND_QUERY;
            sel  = $urandom_range(0, 19);
            if (sel < 7) begin
               colour = seed_colour;
            end else if (sel < 14) begin
               colour = '{nudge(seed_colour.red), nudge(seed_colour.green),
                          nudge(seed_colour.blue)};
            end else if (sel < 16) begin
               colour = '{extreme_component(), extreme_component(), extreme_component()};
            end
         end
         issue_request(kind, index, colour, 1'b0, '0);
         maybe_pause(n);
         n++;
      end
      start <= 1'b0;

      // Drain outstanding queries, then watch for stray strobes
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0)
         $display("nearest_palette_color_top_tb: clean");
      else
         $display("nearest_palette_color_top_tb: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/npc_pkg.sv
design/npc_cell.sv
design/nearest_palette_color_top.sv
tb/nearest_palette_color_top_tb.sv
